// File: sv/paps_pkg.sv
// Shared types and constants of the phase-alternated pair stacker.
`default_nettype none

package paps_pkg;

   // Default sizes of the record ring.
   localparam int RING_RECORDS_DEF     = 16;
   localparam int MAX_RECORD_WORDS_DEF = 256;

   // Fixed field and register widths.
   localparam int SAMPLE_W     = 16;
   localparam int MODE_W       = 16;
   localparam int POINT_W      = 8;
   localparam int DEPTH_REG_W  = 5;
   localparam int WORDS_REG_W  = 9;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   // Item operation codes.
   typedef enum logic {
      OP_PUSH    = 1'b0,
      OP_REQUEST = 1'b1
   } op_type;

   // Configuration register index, taken from the word address.
   typedef enum logic {
      REG_STACK_DEPTH  = 1'b0,
      REG_RECORD_WORDS = 1'b1
   } reg_index_type;

   // Weight applied to one record during stacking.
   typedef enum logic [1:0] {
      WT_PLUS1  = 2'd0,
      WT_PLUS2  = 2'd1,
      WT_MINUS2 = 2'd2
   } weight_type;

   // Request sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_ACCUM  = 2'd1,
      ST_DIVIDE = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

endpackage

`default_nettype wire

// File: sv/paps_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module paps_ram #(
   parameter int WIDTH = paps_pkg::SAMPLE_W,
   parameter int DEPTH = paps_pkg::RING_RECORDS_DEF * paps_pkg::MAX_RECORD_WORDS_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/phase_alternated_pair_stacker_unit.sv
// Phase-alternated pair stacker: record ring, stacking sequencer and shared divider.
//
// The request channel (req_*) carries push and request items; the response channel
// (rsp_*) returns one result for each request and none for a push. An item is taken
// at a clock edge where req_valid is high and req_stall low.
// A push writes at most one word into the record ring; the block stays ready, so
// a further item can be taken on the next cycle.
// A request reads the held records one per cycle from the single ring read port,
// accumulating them in one adder, then runs a restoring divider one quotient bit
// per cycle, and waits in ST_FINISH until the output register is free; a request
// that cannot be answered goes straight from ST_IDLE to ST_FINISH. req_stall is
// high throughout.
// The result sits in an output register and holds there while rsp_stall is high,
// so pushes are taken while it waits; a further request completes only once that
// register has been emptied.
// The configuration port holds stack_depth at 0x0 and record_words at 0x4. The user
// must write it only while the block is idle (not enforced). pready is always high.
// Synchronous reset empties the ring bookkeeping, drops any pending result and
// sets stack_depth to 2 and record_words to 1; the ring memory is not cleared.
`default_nettype none

module phase_alternated_pair_stacker_unit #(
   parameter int RING_RECORDS     = paps_pkg::RING_RECORDS_DEF,
   parameter int MAX_RECORD_WORDS = paps_pkg::MAX_RECORD_WORDS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_operation,
   input  wire logic [paps_pkg::MODE_W-1:0]         req_well_mode,
   input  wire logic                                req_phase_negative,
   input  wire logic signed [paps_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic [paps_pkg::POINT_W-1:0]        req_point_index,
   // Response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [paps_pkg::SAMPLE_W-1:0]            rsp_stacked_point,
   output logic                                     rsp_data_valid,
   // Configuration port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [paps_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [paps_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [paps_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                     pready
);

   localparam int SLOT_W   = $clog2(RING_RECORDS);
   localparam int POS_W    = $clog2(MAX_RECORD_WORDS);
   localparam int HELD_W   = $clog2(RING_RECORDS + 1);
   localparam int WORDS_W  = $clog2(MAX_RECORD_WORDS + 1);
   localparam int CMP_DW   = (paps_pkg::DEPTH_REG_W > HELD_W) ? paps_pkg::DEPTH_REG_W : HELD_W;
   localparam int CMP_WW   = (paps_pkg::WORDS_REG_W > WORDS_W) ? paps_pkg::WORDS_REG_W : WORDS_W;
   localparam int IDX_W    = (paps_pkg::POINT_W > POS_W) ? paps_pkg::POINT_W : POS_W;
   localparam int PCMP_W   = (IDX_W > WORDS_W) ? IDX_W : WORDS_W;
   localparam int SUM_W    = paps_pkg::SAMPLE_W + 3 + SLOT_W;
   localparam int DIV_W    = HELD_W + 1;
   localparam int CNT_W    = $clog2(SUM_W);
   localparam int RAM_DEPTH = RING_RECORDS * (2 ** POS_W);
   localparam int RAM_AW   = SLOT_W + POS_W;

   // Configuration registers.
   logic [paps_pkg::DEPTH_REG_W-1:0] stack_depth_ff;
   logic [paps_pkg::WORDS_REG_W-1:0] record_words_ff;
   logic                             cfg_write;
   paps_pkg::reg_index_type          cfg_sel;

   // Ring bookkeeping.
   logic [SLOT_W-1:0]           oldest_ff, oldest_in;
   logic [HELD_W-1:0]           held_ff, held_in;
   logic [POS_W-1:0]            word_pos_ff, word_pos_in;
   logic [paps_pkg::MODE_W-1:0] prev_mode_ff;
   logic                        discard_ff, discard_in;

   // Effective (clamped) configuration.
   logic [CMP_DW-1:0]  depth_raw;
   logic [CMP_WW-1:0]  words_raw;
   logic [HELD_W-1:0]  eff_depth;
   logic [WORDS_W-1:0] eff_words;

   // Push path.
   logic               in_accept, push_en, start_req, req_ok;
   logic               first_word, mode_chg;
   logic [SLOT_W-1:0]  oldest_a;
   logic [HELD_W-1:0]  held_a;
   logic [HELD_W:0]    slot_sum;
   logic [SLOT_W-1:0]  wr_slot;
   logic               wr_en;
   logic [WORDS_W-1:0] pos_plus;
   logic [PCMP_W-1:0]  point_cmp;
   logic [PCMP_W-1:0]  words_cmp;

   // Request sequencer and datapath.
   paps_pkg::state_type  state_ff, state_in;
   logic [HELD_W-1:0]    depth_ff;
   logic [IDX_W-1:0]     point_ff;
   logic                 ok_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [HELD_W-1:0]    issue_cnt_ff;
   logic                 pipe_vld_ff;
   paps_pkg::weight_type pipe_wt_ff, issue_wt;
   logic signed [SUM_W-1:0] acc_ff, acc_term, v_ext;
   logic                 issue_en, acc_done, div_step, div_last, out_load;
   logic [RAM_AW-1:0]    rd_addr;
   logic [paps_pkg::SAMPLE_W-1:0] rd_data;

   // Divider.
   logic [SUM_W-1:0]  quo_ff;
   logic [DIV_W-1:0]  rem_ff, divisor_ff;
   logic [DIV_W:0]    rem_shift;
   logic              quo_bit;
   logic [DIV_W-1:0]  rem_next;
   logic              neg_ff;
   logic [CNT_W-1:0]  div_cnt_ff;
   logic [SUM_W-1:0]  quo_signed;

   // Output register.
   logic                          rsp_valid_ff;
   logic [paps_pkg::SAMPLE_W-1:0] rsp_point_ff;
   logic                          rsp_dv_ff;

   // Configuration port decode.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign cfg_sel   = paps_pkg::reg_index_type'(paddr[2]);

   always_comb begin
      unique case (cfg_sel)
         paps_pkg::REG_STACK_DEPTH:  prdata = paps_pkg::CSR_DATA_W'(stack_depth_ff);
         paps_pkg::REG_RECORD_WORDS: prdata = paps_pkg::CSR_DATA_W'(record_words_ff);
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_depth_ff  <= paps_pkg::DEPTH_REG_W'(2);
         record_words_ff <= paps_pkg::WORDS_REG_W'(1);
      end else if (cfg_write) begin
         if (cfg_sel == paps_pkg::REG_STACK_DEPTH) begin
            stack_depth_ff <= pwdata[paps_pkg::DEPTH_REG_W-1:0];
         end else begin
            record_words_ff <= pwdata[paps_pkg::WORDS_REG_W-1:0];
         end
      end
   end

   // Clamp the depth and record length into their usable ranges.
   always_comb begin
      depth_raw = CMP_DW'(stack_depth_ff);
      if (depth_raw < CMP_DW'(2)) begin
         depth_raw = CMP_DW'(2);
      end else if (depth_raw > CMP_DW'(RING_RECORDS)) begin
         depth_raw = CMP_DW'(RING_RECORDS);
      end
      eff_depth = depth_raw[HELD_W-1:0];

      words_raw = CMP_WW'(record_words_ff);
      if (words_raw < CMP_WW'(1)) begin
         words_raw = CMP_WW'(1);
      end else if (words_raw > CMP_WW'(MAX_RECORD_WORDS)) begin
         words_raw = CMP_WW'(MAX_RECORD_WORDS);
      end
      eff_words = words_raw[WORDS_W-1:0];
   end

   // Input handshake.
   assign req_stall = (state_ff != paps_pkg::ST_IDLE);
   assign in_accept = req_valid && !req_stall;
   assign push_en   = in_accept && (req_operation == paps_pkg::OP_PUSH);
   assign start_req = in_accept && (req_operation == paps_pkg::OP_REQUEST);

   // A request is answerable only with a full stack and a point inside the record.
   assign point_cmp = PCMP_W'(req_point_index);
   assign words_cmp = PCMP_W'(eff_words);
   assign req_ok    = (held_ff == eff_depth) && (point_cmp < words_cmp);

   // Push bookkeeping: mode change, discard decision, ring advance and write slot.
   always_comb begin
      first_word = (word_pos_ff == '0);
      mode_chg   = first_word && (req_well_mode != prev_mode_ff);
      oldest_a   = mode_chg ? '0 : oldest_ff;
      held_a     = mode_chg ? '0 : held_ff;
      oldest_in  = oldest_a;
      held_in    = held_a;
      discard_in = discard_ff;
      if (first_word) begin
         if ((held_a == '0) && req_phase_negative) begin
            discard_in = 1'b1;
         end else begin
            discard_in = 1'b0;
            if (held_a >= eff_depth) begin
               oldest_in = (oldest_a == SLOT_W'(RING_RECORDS - 1)) ? '0 : oldest_a + 1'b1;
            end else begin
               held_in = held_a + 1'b1;
            end
         end
      end

      // Newest record sits at oldest + held - 1, modulo the ring size.
      slot_sum = (HELD_W + 1)'(oldest_in) + (HELD_W + 1)'(held_in) - (HELD_W + 1)'(1);
      if (slot_sum >= (HELD_W + 1)'(RING_RECORDS)) begin
         slot_sum = slot_sum - (HELD_W + 1)'(RING_RECORDS);
      end
      wr_slot = slot_sum[SLOT_W-1:0];
      wr_en   = push_en && !discard_in && (held_in != '0);

      pos_plus = WORDS_W'(word_pos_ff) + WORDS_W'(1);
      word_pos_in = (pos_plus >= eff_words) ? '0 : word_pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         held_ff      <= '0;
         word_pos_ff  <= '0;
         prev_mode_ff <= '0;
         discard_ff   <= 1'b0;
      end else if (push_en) begin
         oldest_ff   <= oldest_in;
         held_ff     <= held_in;
         word_pos_ff <= word_pos_in;
         discard_ff  <= discard_in;
         if (first_word) begin
            prev_mode_ff <= req_well_mode;
         end
      end
   end

   // Record ring memory.
   assign rd_addr = {slot_ff, point_ff[POS_W-1:0]};

   paps_ram #(
      .WIDTH (paps_pkg::SAMPLE_W),
      .DEPTH (RAM_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({wr_slot, word_pos_ff}),
      .wr_data (req_sample),
      .rd_en   (issue_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         paps_pkg::ST_IDLE: begin
            if (start_req) begin
               state_in = req_ok ? paps_pkg::ST_ACCUM : paps_pkg::ST_FINISH;
            end
         end
         paps_pkg::ST_ACCUM: begin
            if (acc_done) begin
               state_in = paps_pkg::ST_DIVIDE;
            end
         end
         paps_pkg::ST_DIVIDE: begin
            if (div_last) begin
               state_in = paps_pkg::ST_FINISH;
            end
         end
         paps_pkg::ST_FINISH: begin
            if (out_load) begin
               state_in = paps_pkg::ST_IDLE;
            end
         end
         default: state_in = paps_pkg::ST_IDLE;
      endcase
   end

   // Sequencer: control outputs.
   always_comb begin
      issue_en = (state_ff == paps_pkg::ST_ACCUM) && (issue_cnt_ff != depth_ff);
      acc_done = (state_ff == paps_pkg::ST_ACCUM) && (issue_cnt_ff == depth_ff) && !pipe_vld_ff;
      div_step = (state_ff == paps_pkg::ST_DIVIDE);
      div_last = div_step && (div_cnt_ff == CNT_W'(SUM_W - 1));
      out_load = (state_ff == paps_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= paps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Weight of the record being issued: ends +1, interior alternating +2 and -2.
   always_comb begin
      if ((issue_cnt_ff == '0) || (issue_cnt_ff == depth_ff - 1'b1)) begin
         issue_wt = paps_pkg::WT_PLUS1;
      end else if (issue_cnt_ff[0]) begin
         issue_wt = paps_pkg::WT_MINUS2;
      end else begin
         issue_wt = paps_pkg::WT_PLUS2;
      end
   end

   // Accumulator term from the word read in the cycle before.
   always_comb begin
      v_ext = SUM_W'($signed(rd_data));
      unique case (pipe_wt_ff)
         paps_pkg::WT_PLUS1:  acc_term = v_ext;
         paps_pkg::WT_PLUS2:  acc_term = v_ext <<< 1;
         paps_pkg::WT_MINUS2: acc_term = -(v_ext <<< 1);
         default:             acc_term = '0;
      endcase
   end

   // One restoring division step.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      quo_bit   = (rem_shift >= {1'b0, divisor_ff});
      rem_next  = quo_bit ? DIV_W'(rem_shift - {1'b0, divisor_ff}) : rem_shift[DIV_W-1:0];
      quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   end

   // Request datapath: read walk, accumulation and division.
   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_vld_ff <= 1'b0;
      end else begin
         pipe_vld_ff <= issue_en;
      end
   end

   always_ff @(posedge clock) begin
      if (start_req) begin
         depth_ff     <= eff_depth;
         point_ff     <= IDX_W'(req_point_index);
         ok_ff        <= req_ok;
         slot_ff      <= oldest_ff;
         issue_cnt_ff <= '0;
         acc_ff       <= '0;
      end else begin
         if (issue_en) begin
            pipe_wt_ff   <= issue_wt;
            issue_cnt_ff <= issue_cnt_ff + 1'b1;
            slot_ff      <= (slot_ff == SLOT_W'(RING_RECORDS - 1)) ? '0 : slot_ff + 1'b1;
         end
         if (pipe_vld_ff) begin
            acc_ff <= acc_ff + acc_term;
         end
      end

      if (acc_done) begin
         neg_ff     <= acc_ff[SUM_W-1];
         quo_ff     <= acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : SUM_W'(acc_ff);
         rem_ff     <= '0;
         div_cnt_ff <= '0;
         divisor_ff <= {depth_ff - 1'b1, 1'b0};
      end else if (div_step) begin
         quo_ff     <= {quo_ff[SUM_W-2:0], quo_bit};
         rem_ff     <= rem_next;
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_point_ff <= ok_ff ? quo_signed[paps_pkg::SAMPLE_W-1:0] : '0;
         rsp_dv_ff    <= ok_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stacked_point = rsp_point_ff;
   assign rsp_data_valid    = rsp_dv_ff;

`ifndef SYNTH
   // A taken request holds off the next item.
   assert property (@(posedge clock) disable iff (reset)
      start_req |=> req_stall)
      else $error("Request taken but the input was not stalled.");

   // A result appears only out of the final sequencer state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == paps_pkg::ST_FINISH))
      else $error("Result raised outside the final state.");

   // The ring never claims more records than it has slots.
   assert property (@(posedge clock) disable iff (reset)
      held_ff <= HELD_W'(RING_RECORDS))
      else $error("Record count exceeds the ring size.");

   // The partial remainder stays below the divisor throughout division.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == paps_pkg::ST_DIVIDE) |-> (rem_ff < divisor_ff))
      else $error("Divider remainder out of range.");
`endif

endmodule

`default_nettype wire

// File: verif/tb_phase_alternated_pair_stacker_unit.sv
// Self-checking testbench for the phase-alternated pair stacker unit.
`timescale 1ns / 100ps

module tb_phase_alternated_pair_stacker_unit;

   localparam int RING         = paps_pkg::RING_RECORDS_DEF;
   localparam int MAXW         = paps_pkg::MAX_RECORD_WORDS_DEF;
   localparam int DRAIN_CYCLES = 64;
   localparam logic [paps_pkg::CSR_DATA_W-1:0] DEPTH_MASK = (1 << paps_pkg::DEPTH_REG_W) - 1;
   localparam logic [paps_pkg::CSR_DATA_W-1:0] WORDS_MASK = (1 << paps_pkg::WORDS_REG_W) - 1;

   typedef struct {
      paps_pkg::op_type                 op;
      logic [paps_pkg::MODE_W-1:0]      mode;
      logic                             neg;
      logic [paps_pkg::SAMPLE_W-1:0]    sample;
      logic [paps_pkg::POINT_W-1:0]     point;
   } stack_item_type;

   typedef struct {
      logic [paps_pkg::SAMPLE_W-1:0] point;
      logic                          valid;
   } stack_result_type;

   typedef enum {
      STALL_NONE,
      STALL_SPARSE,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_pattern_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_operation = 1'b0;
   logic [paps_pkg::MODE_W-1:0] req_well_mode = '0;
   logic req_phase_negative = 1'b0;
   logic signed [paps_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic [paps_pkg::POINT_W-1:0] req_point_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [paps_pkg::SAMPLE_W-1:0] rsp_stacked_point;
   logic rsp_data_valid;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [paps_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [paps_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [paps_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   phase_alternated_pair_stacker_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_well_mode      (req_well_mode),
      .req_phase_negative (req_phase_negative),
      .req_sample         (req_sample),
      .req_point_index    (req_point_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_stacked_point  (rsp_stacked_point),
      .rsp_data_valid     (rsp_data_valid),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // Mirror of the block's ring and bookkeeping.
   logic [paps_pkg::SAMPLE_W-1:0]    ring_word [RING*MAXW];
   bit                               ring_filled [RING*MAXW];
   int unsigned                      oldest_rec = 0;
   int unsigned                      held_recs = 0;
   int unsigned                      word_pos = 0;
   logic [paps_pkg::MODE_W-1:0]      last_mode = '0;
   bit                               dropping_record = 1'b0;
   logic [paps_pkg::DEPTH_REG_W-1:0] depth_reg = 5'd2;
   logic [paps_pkg::WORDS_REG_W-1:0] words_reg = 9'd1;

   stack_result_type pending_points[$];
   int unsigned   mismatch_count = 0;
   int unsigned   burst_left = 0;
   logic [paps_pkg::MODE_W-1:0] stream_mode = '0;
   logic          record_negative = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #12ms;
      $display("tb_phase_alternated_pair_stacker_unit NOT OK");
      $finish;
   end

   task automatic report_mismatch(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic int unsigned depth_now();
      if (depth_reg < 2) return 2;
      if (depth_reg > RING) return RING;
      return depth_reg;
   endfunction

   function automatic int unsigned words_now();
      if (words_reg < 1) return 1;
      if (words_reg > MAXW) return MAXW;
      return words_reg;
   endfunction

   // True when a point request would be answered from ring words never written.
   function automatic bit reads_unfilled(logic [paps_pkg::POINT_W-1:0] pt);
      int unsigned k;
      if (held_recs != depth_now() || pt >= words_now()) return 1'b0;
      for (k = 0; k < depth_now(); k++) begin
         if (!ring_filled[((oldest_rec + k) % RING) * MAXW + pt]) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Weighted sum over the held records, oldest first, scaled by 2*(depth-1).
   function automatic stack_result_type stacked_point_for(logic [paps_pkg::POINT_W-1:0] pt);
      stack_result_type res;
      int unsigned d;
      int unsigned k;
      int sum;
      int v;
      int quotient;
      d = depth_now();
      res.point = '0;
      res.valid = 1'b0;
      if (held_recs != d || pt >= words_now()) return res;
      sum = 0;
      for (k = 1; k <= d; k++) begin
         v = int'($signed(ring_word[((oldest_rec + k - 1) % RING) * MAXW + pt]));
         if (k == 1 || k == d) sum += v;
         else if (k % 2 == 0) sum -= 2 * v;
         else sum += 2 * v;
      end
      quotient = sum / int'(2 * (d - 1));
      res.point = quotient[paps_pkg::SAMPLE_W-1:0];
      res.valid = 1'b1;
      return res;
   endfunction

   // Ring update for one pushed word.
   task automatic store_record_word(logic [paps_pkg::MODE_W-1:0] mode, logic neg,
                                    logic [paps_pkg::SAMPLE_W-1:0] sample);
      int unsigned d;
      int unsigned w;
      int unsigned slot;
      d = depth_now();
      w = words_now();
      if (word_pos == 0) begin
         if (mode != last_mode) begin
            oldest_rec = 0;
            held_recs = 0;
         end
         last_mode = mode;
         if (held_recs == 0 && neg) begin
            dropping_record = 1'b1;
         end else begin
            dropping_record = 1'b0;
            if (held_recs >= d) oldest_rec = (oldest_rec + 1) % RING;
            else held_recs++;
         end
      end
      if (!dropping_record && held_recs != 0) begin
         slot = (oldest_rec + held_recs - 1) % RING;
         ring_word[slot * MAXW + word_pos % MAXW] = sample;
         ring_filled[slot * MAXW + word_pos % MAXW] = 1'b1;
      end
      if (word_pos + 1 >= w) word_pos = 0;
      else word_pos++;
   endtask

   // Sends one item and records its effect once it has been taken.
   task automatic send_item(stack_item_type it);
      int unsigned gap;
      // A read-out that would touch never-written words is turned aside.
      if (it.op == paps_pkg::OP_REQUEST && reads_unfilled(it.point)) begin
         if (words_now() < MAXW)
            it.point = paps_pkg::POINT_W'($urandom_range(words_now(), 255));
         else
            it.op = paps_pkg::OP_PUSH;
      end
      req_valid          <= 1'b1;
      req_operation      <= it.op;
      req_well_mode      <= it.mode;
      req_phase_negative <= it.neg;
      req_sample         <= it.sample;
      req_point_index    <= it.point;
      do @(posedge clock); while (req_stall);
      if (it.op == paps_pkg::OP_PUSH) store_record_word(it.mode, it.neg, it.sample);
      else pending_points.push_back(stacked_point_for(it.point));
      // Bursts of back-to-back requests separated by idle gaps.
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 16);
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   task automatic push_echo_word(logic [paps_pkg::MODE_W-1:0] mode, logic neg,
                                 logic [paps_pkg::SAMPLE_W-1:0] sample);
      stack_item_type it;
      it.op = paps_pkg::OP_PUSH;
      it.mode = mode;
      it.neg = neg;
      it.sample = sample;
      it.point = paps_pkg::POINT_W'($urandom);
      send_item(it);
   endtask

   task automatic ask_stacked_point(logic [paps_pkg::POINT_W-1:0] pt);
      stack_item_type it;
      it.op = paps_pkg::OP_REQUEST;
      it.mode = paps_pkg::MODE_W'($urandom);
      it.neg = 1'($urandom);
      it.sample = paps_pkg::SAMPLE_W'($urandom);
      it.point = pt;
      send_item(it);
   endtask

   // Register write followed by a read-back; unused data bits carry noise.
   task automatic write_csr(paps_pkg::reg_index_type idx,
                            logic [paps_pkg::CSR_DATA_W-1:0] value,
                            logic [paps_pkg::CSR_DATA_W-1:0] mask);
      logic [paps_pkg::CSR_DATA_W-1:0] data;
      logic [paps_pkg::CSR_DATA_W-1:0] got;
      data = (paps_pkg::CSR_DATA_W'($urandom) & ~mask) | (value & mask);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         paps_pkg::REG_STACK_DEPTH:  depth_reg = data[paps_pkg::DEPTH_REG_W-1:0];
         paps_pkg::REG_RECORD_WORDS: words_reg = data[paps_pkg::WORDS_REG_W-1:0];
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      if (got !== (data & mask))
         report_mismatch($sformatf("register %s read back %0h, wrote %0h",
                                   idx.name(), got, data & mask));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until the block is idle, then sets both registers.
   task automatic settle_and_configure(int unsigned depth_val, int unsigned words_val);
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_csr(paps_pkg::REG_STACK_DEPTH, depth_val, DEPTH_MASK);
      write_csr(paps_pkg::REG_RECORD_WORDS, words_val, WORDS_MASK);
   endtask

   // Empty ring: read-outs are invalid and a negative-phase first record is dropped.
   task automatic test_empty_ring();
      ask_stacked_point(8'hFF);
      push_echo_word(16'h0000, 1'b1, 16'h1234);
      ask_stacked_point(8'h00);
   endtask

   // Out-of-range register values, truncation toward zero, oldest record dropped.
   task automatic test_range_saturation();
      settle_and_configure(0, 0);
      push_echo_word(16'h0000, 1'b0, 16'h7FFF);
      ask_stacked_point(8'h00);
      push_echo_word(16'h0000, 1'b1, 16'h8000);
      ask_stacked_point(8'h00);
      ask_stacked_point(8'h01);
      push_echo_word(16'h0000, 1'b0, 16'h8000);
      ask_stacked_point(8'h00);
      settle_and_configure(31, 511);
      ask_stacked_point(8'hFF);
   endtask

   // Depth lowered below the records held: invalid until the mode changes.
   task automatic test_depth_lowered();
      settle_and_configure(3, 1);
      push_echo_word(16'hFFFF, 1'b0, 16'd100);
      push_echo_word(16'hFFFF, 1'b1, -16'sd7);
      push_echo_word(16'hFFFF, 1'b0, 16'd3);
      ask_stacked_point(8'h00);
      settle_and_configure(2, 1);
      push_echo_word(16'hFFFF, 1'b0, 16'd5);
      ask_stacked_point(8'h00);
      push_echo_word(16'h0000, 1'b0, 16'd9);
   endtask

   // Read-out while a record fills, then the record length shrinks under it.
   task automatic test_record_cut_short();
      settle_and_configure(2, 4);
      push_echo_word(16'h0000, 1'b0, 16'h0F0F);
      push_echo_word(16'h0000, 1'b1, 16'hF0F0);
      ask_stacked_point(8'h00);
      settle_and_configure(2, 2);
      push_echo_word(16'h0000, 1'b0, 16'h5555);
      ask_stacked_point(8'h03);
      ask_stacked_point(8'h00);
   endtask

   // One setting of the registers followed by mostly well-formed record streams.
   task automatic run_stacking_phase(int unsigned depth_val, int unsigned words_val,
                                     int unsigned n_items);
      stack_item_type it;
      int unsigned d;
      int unsigned w;
      settle_and_configure(depth_val, words_val);
      d = depth_now();
      w = words_now();
      repeat (n_items) begin
         it.mode = stream_mode;
         it.neg = record_negative;
         it.point = paps_pkg::POINT_W'($urandom);
         case ($urandom_range(0, 9))
            0: it.sample = 16'h8000;
            1: it.sample = 16'h7FFF;
            default: it.sample = paps_pkg::SAMPLE_W'($urandom);
         endcase
         if ($urandom_range(0, 99) < ((held_recs == d) ? 25 : 6)) begin
            it.op = paps_pkg::OP_REQUEST;
            it.mode = paps_pkg::MODE_W'($urandom);
            it.neg = 1'($urandom);
            if (w < MAXW && $urandom_range(0, 99) < 15)
               it.point = paps_pkg::POINT_W'($urandom_range(w, 255));
            else
               it.point = paps_pkg::POINT_W'($urandom_range(0, w - 1));
         end else begin
            it.op = paps_pkg::OP_PUSH;
            if (word_pos == 0) begin
               // New record: phases alternate, with the odd slip and mode change.
               if ($urandom_range(0, 99) < 3) stream_mode = paps_pkg::MODE_W'($urandom);
               if (held_recs == 0) record_negative = ($urandom_range(0, 99) < 20);
               else record_negative = ~record_negative ^ ($urandom_range(0, 9) == 0);
               it.mode = stream_mode;
               it.neg = record_negative;
            end else if ($urandom_range(0, 9) == 0) begin
               it.mode = paps_pkg::MODE_W'($urandom);
               it.neg = 1'($urandom);
            end
         end
         send_item(it);
      end
   endtask

   task automatic test_random_stacking();
      int unsigned sent;
      int unsigned depth_val;
      int unsigned words_val;
      int unsigned n;
      run_stacking_phase(16, 1, 120);
      run_stacking_phase(31, 2, 80);
      run_stacking_phase(1, 511, 340);
      run_stacking_phase(0, 0, 60);
      sent = 600;
      while (sent < 1250) begin
         case ($urandom_range(0, 9))
            0: depth_val = $urandom_range(0, 1);
            1: depth_val = 16;
            2: depth_val = $urandom_range(17, 31);
            default: depth_val = $urandom_range(2, 6);
         endcase
         case ($urandom_range(0, 19))
            0, 1: words_val = 0;
            2, 3, 4: words_val = $urandom_range(9, 40);
            default: words_val = $urandom_range(1, 8);
         endcase
         n = $urandom_range(50, 110);
         run_stacking_phase(depth_val, words_val, n);
         sent += n;
      end
   endtask

   // Result checking and the receiver's own stall pattern.
   stall_pattern_type stall_pattern = STALL_NONE;
   int unsigned       pattern_left = 0;
   int unsigned       stall_tick = 0;

   always @(posedge clock) begin : result_check
      stack_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            report_mismatch("result arrived with no point request outstanding");
         end else begin
            want = pending_points.pop_front();
            if (rsp_data_valid !== want.valid)
               report_mismatch($sformatf("data_valid %b, expected %b",
                                         rsp_data_valid, want.valid));
            if (rsp_stacked_point !== want.point)
               report_mismatch($sformatf("stacked_point %h, expected %h",
                                         rsp_stacked_point, want.point));
         end
      end
      if (pattern_left == 0) begin
         stall_pattern = stall_pattern_type'($urandom_range(0, 3));
         pattern_left = $urandom_range(30, 200);
      end else begin
         pattern_left--;
      end
      stall_tick++;
      case (stall_pattern)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_SPARSE:   rsp_stall <= ($urandom_range(0, 99) < 30);
         STALL_PERIODIC: rsp_stall <= (stall_tick % 7 < 3);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 99) < 70);
      endcase
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_ring();
      test_range_saturation();
      test_depth_lowered();
      test_record_cut_short();
      test_random_stacking();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_points.size() != 0)
         report_mismatch("point requests left without a result");
      if (mismatch_count == 0) begin
         $display("tb_phase_alternated_pair_stacker_unit OK");
      end else begin
         $display("tb_phase_alternated_pair_stacker_unit NOT OK");
      end
      $finish;
   end

endmodule
